>>> rtl/core/cbez_pkg.sv
`default_nettype none

package cbez_pkg;

	// Sample count of one segment: t = j / SAMPLES.
	localparam int SAMPLES = 100;

	// Field and datapath widths.
	localparam int COORD_W = 16;               // signed Q8.8 coordinate
	localparam int IDX_W   = 7;                // sample index
	localparam int IDX_N   = 2 ** IDX_W;       // every code of the index field
	localparam int FRAC_W  = 16;               // fraction bits of t (Q0.16)
	localparam int COEF_W  = 20;               // basis coefficients a, b, c
	localparam int ACC_W   = 22;               // Horner accumulator, Q14.8 unsaturated
	localparam int PROD_W  = ACC_W + FRAC_W + 2;

	typedef logic [FRAC_W-1:0] t_frac_t;
	typedef t_frac_t t_lut_t [IDX_N];

	// t for every index code. Indices at or above the sample count clamp to the
	// last sample, so t stays below one.
	function automatic t_lut_t build_t_lut();
		t_lut_t lut;
		int     j;
		for (int i = 0; i < IDX_N; i++) begin
			j      = (i > SAMPLES - 1) ? SAMPLES - 1 : i;
			lut[i] = FRAC_W'((j * (2 ** FRAC_W)) / SAMPLES);
		end
		return lut;
	endfunction

	localparam t_lut_t T_LUT = build_t_lut();

endpackage

`default_nettype wire

>>> rtl/core/cbez_lane.sv
`default_nettype none

module cbez_lane import cbez_pkg::*; (
	input  logic                      clk,
	input  logic signed [COORD_W-1:0] p0,
	input  logic signed [COORD_W-1:0] p1,
	input  logic signed [COORD_W-1:0] p2,
	input  logic signed [COORD_W-1:0] p3,
	input  t_frac_t                   t,
	output logic signed [ACC_W-1:0]   res
);

	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

	// One Horner step: round(acc * t + k), with k scaled up to Q8.24, half up.
	function automatic logic signed [ACC_W-1:0] horner_step(
		input logic signed [ACC_W-1:0]  acc,
		input t_frac_t                  tv,
		input logic signed [COEF_W-1:0] k
	);
		logic signed [PROD_W-1:0] prod;
		logic signed [PROD_W-1:0] sum;
		prod = PROD_W'(acc) * PROD_W'($signed({1'b0, tv}));
		sum  = prod + (PROD_W'(k) <<< FRAC_W) + ROUND_HALF;
		return ACC_W'(sum >>> FRAC_W);
	endfunction

	logic signed [COEF_W-1:0] e0, e1, e2, e3, d01, d12, bb;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1, d_s1, c_s2, d_s2, d_s3;
	t_frac_t                  t_s1, t_s2, t_s3;
	logic signed [ACC_W-1:0]  r_s2, r_s3, r_s4;

	// Basis matrix applied to the control points.
	always_comb begin
		e0  = COEF_W'(p0);
		e1  = COEF_W'(p1);
		e2  = COEF_W'(p2);
		e3  = COEF_W'(p3);
		d01 = e1 - e0;
		d12 = e1 - e2;
		bb  = e0 - (e1 <<< 1) + e2;
	end

	always_ff @(posedge clk) begin
		a_s1 <= (e3 - e0) + (d12 <<< 1) + d12;
		b_s1 <= (bb <<< 1) + bb;
		c_s1 <= (d01 <<< 1) + d01;
		d_s1 <= e0;
		t_s1 <= t;

		r_s2 <= horner_step(ACC_W'(a_s1), t_s1, b_s1);
		c_s2 <= c_s1;
		d_s2 <= d_s1;
		t_s2 <= t_s1;

		r_s3 <= horner_step(r_s2, t_s2, c_s2);
		d_s3 <= d_s2;
		t_s3 <= t_s2;

		r_s4 <= horner_step(r_s3, t_s3, d_s3);
	end

	assign res = r_s4;

endmodule

`default_nettype wire

>>> rtl/core/cbez_merge.sv
`default_nettype none

module cbez_merge import cbez_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic signed [ACC_W-1:0]   x_res,
	input  logic signed [ACC_W-1:0]   y_res,
	output logic                      done,
	output logic signed [COORD_W-1:0] curve_x,
	output logic signed [COORD_W-1:0] curve_y
);

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'((2 ** (COORD_W - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(2 ** (COORD_W - 1));

	function automatic logic signed [COORD_W-1:0] sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		if (v > SAT_MAX) begin
			c = SAT_MAX;
		end else if (v < SAT_MIN) begin
			c = SAT_MIN;
		end else begin
			c = v;
		end
		return COORD_W'(c);
	endfunction

	logic                      done_q;
	logic signed [COORD_W-1:0] x_q, y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= sat(x_res);
		y_q <= sat(y_res);
	end

	assign done    = done_q;
	assign curve_x = x_q;
	assign curve_y = y_q;

endmodule

`default_nettype wire

>>> rtl/core/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: one x/y point per accepted beat.
// done rises for the result once the beat has passed the lane stages and the merge register.
// Throughput: one beat per cycle; busy is always low, since the receiver cannot stall.
// Rate is set by the five-stage pipeline: one multiply-accumulate stage per Horner step.
// Reset: arst_n low clears the valid chain and done asynchronously; data registers keep state.
`default_nettype none

module cubic_bezier_point_eval import cbez_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [COORD_W-1:0] p0_x,
	input  logic signed [COORD_W-1:0] p0_y,
	input  logic signed [COORD_W-1:0] p1_x,
	input  logic signed [COORD_W-1:0] p1_y,
	input  logic signed [COORD_W-1:0] p2_x,
	input  logic signed [COORD_W-1:0] p2_y,
	input  logic signed [COORD_W-1:0] p3_x,
	input  logic signed [COORD_W-1:0] p3_y,
	input  logic [IDX_W-1:0]          sample_index,
	output logic                      done,
	output logic signed [COORD_W-1:0] curve_x,
	output logic signed [COORD_W-1:0] curve_y
);

	// The pipeline never stalls, so a beat is taken whenever start is high.
	assign busy = 1'b0;

	// The parameter t comes from a constant table over every index code. The
	// clamp of large indices to the last sample is folded into the table.
	t_frac_t t_val;
	assign t_val = T_LUT[sample_index];

	// Valid chain alongside the lanes. Lane stage one loads on the accept edge;
	// stage four holds the final Horner result, which the merge stage saturates.
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Two identical lanes, one per coordinate. Each forms the basis coefficients
	// and runs three Horner steps, one multiply-add-round per stage.
	logic signed [ACC_W-1:0] x_res, y_res;

	cbez_lane u_lane_x (
		.clk (clk),
		.p0  (p0_x),
		.p1  (p1_x),
		.p2  (p2_x),
		.p3  (p3_x),
		.t   (t_val),
		.res (x_res)
	);

	cbez_lane u_lane_y (
		.clk (clk),
		.p0  (p0_y),
		.p1  (p1_y),
		.p2  (p2_y),
		.p3  (p3_y),
		.t   (t_val),
		.res (y_res)
	);

	// The merge stage saturates both lanes and presents them together with done.
	cbez_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.x_res    (x_res),
		.y_res    (y_res),
		.done     (done),
		.curve_x  (curve_x),
		.curve_y  (curve_y)
	);

`ifndef ASSERT_OFF
	// A result strobe always traces back to a beat taken earlier.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("done without an accepted beat");

	// At index zero t is zero and the point is exactly the first control point.
	a_index_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sample_index, 5) == '0) |-> curve_x == $past(p0_x, 5))
		else $error("x at index zero differs from first control point");

	a_index_zero_y: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(sample_index, 5) == '0) |-> curve_y == $past(p0_y, 5))
		else $error("y at index zero differs from first control point");
`endif

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import cbez_pkg::*;

	// One input beat as the bench keeps it: the four control points, the sample
	// index and the number of idle cycles the driver waits before offering it.
	typedef struct packed {
		logic signed [COORD_W-1:0] p0x;
		logic signed [COORD_W-1:0] p0y;
		logic signed [COORD_W-1:0] p1x;
		logic signed [COORD_W-1:0] p1y;
		logic signed [COORD_W-1:0] p2x;
		logic signed [COORD_W-1:0] p2y;
		logic signed [COORD_W-1:0] p3x;
		logic signed [COORD_W-1:0] p3y;
		logic [IDX_W-1:0]          idx;
		logic [4:0]                gap;
	} curve_beat_t;

	// One evaluated point, as the block should return it.
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} curve_point_t;

	localparam int COORD_MAX = 32767;
	localparam int COORD_MIN = -32768;
	localparam int MAX_GAP   = 18;
	localparam int N_RANDOM  = 400;
	localparam int MAX_SHOWN = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_W-1:0] p0_x = '0;
	logic signed [COORD_W-1:0] p0_y = '0;
	logic signed [COORD_W-1:0] p1_x = '0;
	logic signed [COORD_W-1:0] p1_y = '0;
	logic signed [COORD_W-1:0] p2_x = '0;
	logic signed [COORD_W-1:0] p2_y = '0;
	logic signed [COORD_W-1:0] p3_x = '0;
	logic signed [COORD_W-1:0] p3_y = '0;
	logic [IDX_W-1:0] sample_index = '0;
	logic done;
	logic signed [COORD_W-1:0] curve_x;
	logic signed [COORD_W-1:0] curve_y;

	curve_beat_t  pending_beats[$];   // beats still to be offered to the block
	curve_point_t point_q[$];         // predicted points, oldest first
	curve_beat_t  cur_beat;           // beat currently held on the input ports
	int unsigned  idle_left = 0;      // idle cycles left before the next beat
	int unsigned  n_queued = 0;
	int unsigned  n_accepted = 0;
	int unsigned  n_errors = 0;

	cubic_bezier_point_eval dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.p0_x         (p0_x),
		.p0_y         (p0_y),
		.p1_x         (p1_x),
		.p1_y         (p1_y),
		.p2_x         (p2_x),
		.p2_y         (p2_y),
		.p3_x         (p3_x),
		.p3_y         (p3_y),
		.sample_index (sample_index),
		.done         (done),
		.curve_x      (curve_x),
		.curve_y      (curve_y)
	);

	always #5 clk = ~clk;

	// Evaluates one axis of the segment. The basis coefficients are exact Q8.8
	// integers; every Horner step forms acc*t + k in Q8.24 and rounds back to
	// Q8.8 with round half up, which for a signed value is an add of half an LSB
	// followed by an arithmetic shift. Only the final value is clipped.
	function automatic logic signed [COORD_W-1:0] eval_axis(longint q0, longint q1,
			longint q2, longint q3, longint t);
		longint a;
		longint b;
		longint c;
		longint acc;
		a = -q0 + 3 * q1 - 3 * q2 + q3;
		b = 3 * q0 - 6 * q1 + 3 * q2;
		c = -3 * q0 + 3 * q1;
		acc = (a * t + b * 65536 + 32768) >>> 16;
		acc = (acc * t + c * 65536 + 32768) >>> 16;
		acc = (acc * t + q0 * 65536 + 32768) >>> 16;
		if (acc > COORD_MAX)
			acc = COORD_MAX;
		else if (acc < COORD_MIN)
			acc = COORD_MIN;
		return acc[COORD_W-1:0];
	endfunction

	// Expected point for one beat. An index at or past the sample count is held
	// at the last sample, so t never reaches one.
	function automatic curve_point_t predict_point(curve_beat_t bt);
		longint       j;
		longint       t;
		curve_point_t pt;
		j = bt.idx;
		if (j > SAMPLES - 1)
			j = SAMPLES - 1;
		t = (j * 65536) / SAMPLES;
		pt.cx = eval_axis($signed(bt.p0x), $signed(bt.p1x), $signed(bt.p2x),
			$signed(bt.p3x), t);
		pt.cy = eval_axis($signed(bt.p0y), $signed(bt.p1y), $signed(bt.p2y),
			$signed(bt.p3y), t);
		return pt;
	endfunction

	task automatic add_beat(int x0, int y0, int x1, int y1, int x2, int y2,
			int x3, int y3, int j, int gap);
		curve_beat_t bt;
		bt.p0x = x0[COORD_W-1:0];
		bt.p0y = y0[COORD_W-1:0];
		bt.p1x = x1[COORD_W-1:0];
		bt.p1y = y1[COORD_W-1:0];
		bt.p2x = x2[COORD_W-1:0];
		bt.p2y = y2[COORD_W-1:0];
		bt.p3x = x3[COORD_W-1:0];
		bt.p3y = y3[COORD_W-1:0];
		bt.idx = j[IDX_W-1:0];
		bt.gap = gap[4:0];
		pending_beats = {pending_beats, bt};
		n_queued++;
	endtask

	// Random coordinate. Half are drawn over the whole 16-bit code space so that
	// every bit toggles; some stay small, as real control points do, so that the
	// curve mostly lands in range, and a few sit right on the extremes.
	function automatic int rand_coord(int unsigned flavor);
		if (flavor < 5)
			return int'($urandom_range(0, 65535)) - 32768;
		else if (flavor < 9)
			return int'($urandom_range(0, 8191)) - 4096;
		else
			return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
	endfunction

	// Random sample index: mostly inside the segment, sometimes past its end to
	// exercise the clamp, and the full 7-bit range is reachable.
	function automatic int rand_index();
		if ($urandom_range(0, 9) < 8)
			return int'($urandom_range(0, SAMPLES - 1));
		return int'($urandom_range(0, IDX_N - 1));
	endfunction

	// Reset is applied once and released on a clock edge.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver. At each rising edge it first sees whether the beat on the ports
	// was taken (start high, busy low), and if so records its prediction. Then
	// it either keeps the beat, idles, or puts up the next one. Each path makes
	// at most one assignment to start, so a beat offered back to back with the
	// previous one keeps start high without a glitch within the time step.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				point_q = {point_q, predict_point(cur_beat)};
				n_accepted++;
				idle_left = (pending_beats.size() != 0) ? pending_beats[0].gap : 0;
			end
			if (start && busy) begin
				// The block has not taken the beat yet; hold everything.
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left--;
			end else if (pending_beats.size() != 0) begin
				cur_beat = pending_beats.pop_front();
				p0_x <= cur_beat.p0x;
				p0_y <= cur_beat.p0y;
				p1_x <= cur_beat.p1x;
				p1_y <= cur_beat.p1y;
				p2_x <= cur_beat.p2x;
				p2_y <= cur_beat.p2y;
				p3_x <= cur_beat.p3x;
				p3_y <= cur_beat.p3y;
				sample_index <= cur_beat.idx;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. A result is on the ports for exactly one cycle with done high and
	// is taken at the edge that closes that cycle. It must match the oldest
	// prediction field by field; a result with nothing predicted is a failure.
	always @(posedge clk) begin
		if (arst_n && done !== 1'b0) begin
			if (point_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_SHOWN)
					$display("unexpected result: curve_x=%0d curve_y=%0d", curve_x, curve_y);
			end else begin
				curve_point_t want;
				want = point_q.pop_front();
				if (curve_x !== want.cx || curve_y !== want.cy) begin
					n_errors++;
					if (n_errors <= MAX_SHOWN)
						$display("mismatch: curve_x exp %0d got %0d, curve_y exp %0d got %0d",
							want.cx, curve_x, want.cy, curve_y);
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned flavor;
		int          gap;
		int          x0;
		int          y0;

		// Directed beats. All zero, then the corner codes of every coordinate.
		add_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_beat(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, 50, 0);
		add_beat(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, 50, 3);
		// At index zero the point must be exactly the first control point.
		add_beat(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1234, -999, 77, 5, 0, 0);
		add_beat(-1, 1, 256, -256, 12800, -12800, 300, -300, 0, 1);
		// Last sample inside the segment and indices past it, which clamp.
		add_beat(0, 0, 2560, 5120, 7680, -5120, 10240, 2560, SAMPLES - 1, 0);
		add_beat(0, 0, 2560, 5120, 7680, -5120, 10240, 2560, SAMPLES, 0);
		add_beat(0, 0, 2560, 5120, 7680, -5120, 10240, 2560, IDX_N - 1, 0);
		add_beat(-4096, 2048, 1024, -1024, 333, 4444, 4096, -2048, 1, 2);
		// Alternating extremes make the cubic term huge: both saturation sides.
		add_beat(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MIN, 50, 0);
		add_beat(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, 30, 0);
		add_beat(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			COORD_MAX, COORD_MIN, 80, 5);
		add_beat(0, 0, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 0, 0, 50, 0);
		add_beat(0, 0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 0, 0, 50, 0);
		// Straight line from one corner to the other, across the segment.
		add_beat(COORD_MIN, COORD_MIN, -10923, -10923, 10922, 10922, COORD_MAX,
			COORD_MAX, 25, 0);
		add_beat(COORD_MIN, COORD_MIN, -10923, -10923, 10922, 10922, COORD_MAX,
			COORD_MAX, 75, MAX_GAP);
		add_beat(1, -1, 1, -1, 1, -1, 1, -1, 99, 0);
		add_beat(128, -128, 0, 0, 0, 0, 0, 0, 64, 0);
		add_beat(0, 0, 0, 0, 0, 0, 1, -1, 63, 7);
		add_beat(-21555, 21845, 10922, -10923, -21846, 21845, 21845, -21846, 42, 0);

		// Random beats. Runs of back-to-back beats alternate with stretches of
		// random idle gaps, so gaps land on every stage of the pipeline.
		for (int i = 0; i < N_RANDOM; i++) begin
			flavor = $urandom_range(0, 9);
			gap = ((i / 30) % 3 == 0) ? 0 : int'($urandom_range(0, MAX_GAP));
			x0 = rand_coord(flavor);
			y0 = rand_coord(flavor);
			add_beat(x0, y0, rand_coord(flavor), rand_coord(flavor), rand_coord(flavor),
				rand_coord(flavor), rand_coord(flavor), rand_coord(flavor), rand_index(), gap);
		end

		// Wait for every beat to be taken and every point to come back, then a
		// few more cycles to catch any stray result.
		wait (n_accepted == n_queued);
		while (point_q.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (point_q.size() != 0)
			n_errors++;
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
